@@ rtl/nonzero_lane_compaction_buffer_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nonzero lane compaction buffer
// Every macro samples on clock and is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef NONZERO_LANE_COMPACTION_BUFFER_MACROS_SVH
`define NONZERO_LANE_COMPACTION_BUFFER_MACROS_SVH

// Same-cycle implication.
`define NLCB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NLCB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/nlcb_pkg.sv @@
// ----------------------------------------------------------------------------
// nlcb_pkg
// Shared types and defaults for the nonzero lane compaction buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlcb_pkg;

   localparam int LANES_DEF      = 8;
   localparam int DATA_WIDTH_DEF = 32;

   typedef enum logic {
      CMD_PUSH  = 1'b0,
      CMD_PURGE = 1'b1
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } stage_ctrl_type;

endpackage

@@ rtl/nlcb_if.sv @@
// ----------------------------------------------------------------------------
// nlcb_if
// Request and response channels: valid/ready with vector payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nlcb_req_if #(
   parameter int LANES      = 8,
   parameter int DATA_WIDTH = 32
);
   import nlcb_pkg::*;

   logic                                valid;
   logic                                ready;
   cmd_type                             cmd;
   logic [LANES-1:0][DATA_WIDTH-1:0]    lane;

   modport source (output valid, output cmd, output lane, input ready);
   modport sink   (input valid, input cmd, input lane, output ready);
endinterface

interface nlcb_rsp_if #(
   parameter int LANES      = 8,
   parameter int DATA_WIDTH = 32
);
   logic                                valid;
   logic                                ready;
   logic [$clog2(LANES+1)-1:0]          out_count;
   logic [LANES-1:0][DATA_WIDTH-1:0]    out_lane;

   modport source (output valid, output out_count, output out_lane, input ready);
   modport sink   (input valid, input out_count, input out_lane, output ready);
endinterface

@@ rtl/nonzero_lane_compaction_buffer.sv @@
// ----------------------------------------------------------------------------
// nonzero_lane_compaction_buffer
// Drops zero lanes of each vector and packs the rest into full output vectors.
// ----------------------------------------------------------------------------
// Takes one request per clock while responses drain, and returns exactly one
// response per request through the lane registers and then the merge registers.
// Stage one holds each lane with its nonzero flag and its offset among the
// nonzero lanes below it; stage two places those lanes behind the leftover
// values, emits a full vector of LANES values or a zero result, and keeps the
// remainder. A purge returns the leftover values with their count, zero
// filled, and empties the buffer. The leftover count updates within the merge
// stage alone, which allows one vector per cycle while responses drain.
`timescale 1ns / 1ps

module nonzero_lane_compaction_buffer #(
   parameter int LANES      = nlcb_pkg::LANES_DEF,
   parameter int DATA_WIDTH = nlcb_pkg::DATA_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   nlcb_req_if.sink    req_ch,
   nlcb_rsp_if.source  rsp_ch
);
   import nlcb_pkg::*;

   localparam int OW = $clog2(LANES);

   logic                             valid_ff, valid_in;
   cmd_type                          cmd_ff;
   logic                             accept;
   logic                             take;
   stage_ctrl_type                   ctrl;
   logic [LANES-1:0]                 nz_comb;
   logic [LANES-1:0][OW-1:0]         offset_comb;
   logic [LANES-1:0][DATA_WIDTH-1:0] held_value;
   logic [LANES-1:0]                 held_nonzero;
   logic [LANES-1:0][OW-1:0]         held_offset;

   assign req_ch.ready = !valid_ff || take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         offset_comb[i] = '0;
         for (int j = 0; j < LANES; j++) begin
            if (j < i) begin
               offset_comb[i] = offset_comb[i] + OW'(nz_comb[j]);
            end
         end
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      nlcb_lane #(
         .LANES      (LANES),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_lane (
         .clock        (clock),
         .load         (accept),
         .lane_value   (req_ch.lane[g]),
         .lane_offset  (offset_comb[g]),
         .nonzero      (nz_comb[g]),
         .held_value   (held_value[g]),
         .held_nonzero (held_nonzero[g]),
         .held_offset  (held_offset[g])
      );
   end

   assign valid_in = accept ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_ch.cmd;
      end
   end

   assign ctrl.valid = valid_ff;
   assign ctrl.cmd   = cmd_ff;

   nlcb_merge #(
      .LANES      (LANES),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .lane_value   (held_value),
      .lane_nonzero (held_nonzero),
      .lane_offset  (held_offset),
      .take         (take),
      .rsp_ch       (rsp_ch)
   );

endmodule

@@ rtl/nlcb_lane.sv @@
// ----------------------------------------------------------------------------
// nlcb_lane
// One input lane: flags a nonzero value and holds value, flag and its packed
// offset among the nonzero lanes below it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlcb_lane #(
   parameter int LANES      = nlcb_pkg::LANES_DEF,
   parameter int DATA_WIDTH = nlcb_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic [DATA_WIDTH-1:0]        lane_value,
   input  logic [$clog2(LANES)-1:0]     lane_offset,
   output logic                         nonzero,
   output logic [DATA_WIDTH-1:0]        held_value,
   output logic                         held_nonzero,
   output logic [$clog2(LANES)-1:0]     held_offset
);
   localparam int OW = $clog2(LANES);

   logic [DATA_WIDTH-1:0] value_ff;
   logic                  nonzero_ff;
   logic [OW-1:0]         offset_ff;

   assign nonzero = |lane_value;

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff   <= lane_value;
         nonzero_ff <= nonzero;
         offset_ff  <= lane_offset;
      end
   end

   assign held_value   = value_ff;
   assign held_nonzero = nonzero_ff;
   assign held_offset  = offset_ff;

endmodule

@@ rtl/nlcb_merge.sv @@
// ----------------------------------------------------------------------------
// nlcb_merge
// Merge stage: places the nonzero lanes behind the leftover values, emits a
// full vector or a purge, and keeps the remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nonzero_lane_compaction_buffer_macros.svh"

module nlcb_merge #(
   parameter int LANES      = nlcb_pkg::LANES_DEF,
   parameter int DATA_WIDTH = nlcb_pkg::DATA_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nlcb_pkg::stage_ctrl_type              ctrl,
   input  logic [LANES-1:0][DATA_WIDTH-1:0]      lane_value,
   input  logic [LANES-1:0]                      lane_nonzero,
   input  logic [LANES-1:0][$clog2(LANES)-1:0]   lane_offset,
   output logic                                  take,
   nlcb_rsp_if.source                            rsp_ch
);
   import nlcb_pkg::*;

   localparam int CW    = $clog2(LANES + 1);
   localparam int OW    = $clog2(LANES);
   localparam int PW    = $clog2(2 * LANES);
   localparam int SLOTS = 2 * LANES - 1;

   logic [LANES-2:0][DATA_WIDTH-1:0] store_ff, store_in;
   logic [OW-1:0]                    cnt_ff, cnt_in;
   logic                             out_valid_ff, out_valid_in;
   logic [CW-1:0]                    out_count_ff, out_count_in;
   logic [LANES-1:0][DATA_WIDTH-1:0] out_lane_ff, out_lane_in;

   logic [SLOTS-1:0][DATA_WIDTH-1:0] merged;
   logic [CW-1:0]                    nz_total;
   logic [PW-1:0]                    total;
   logic                             full;
   logic                             consume;

   assign take    = !out_valid_ff || rsp_ch.ready;
   assign consume = ctrl.valid && take;

   assign nz_total = CW'(lane_offset[LANES-1]) + CW'(lane_nonzero[LANES-1]);
   assign total    = PW'(cnt_ff) + PW'(nz_total);
   assign full     = total >= PW'(LANES);

   always_comb begin
      merged = '0;
      for (int k = 0; k < LANES - 1; k++) begin
         if (PW'(k) < PW'(cnt_ff)) begin
            merged[k] = store_ff[k];
         end
      end
      for (int k = 0; k < SLOTS; k++) begin
         for (int i = 0; i < LANES; i++) begin
            if (lane_nonzero[i] && (PW'(cnt_ff) + PW'(lane_offset[i]) == PW'(k))) begin
               merged[k] = merged[k] | lane_value[i];
            end
         end
      end
   end

   always_comb begin
      out_lane_in  = '0;
      out_count_in = '0;
      store_in     = store_ff;
      cnt_in       = cnt_ff;
      unique case (ctrl.cmd)
         CMD_PUSH: begin
            if (full) begin
               out_count_in = CW'(LANES);
               for (int k = 0; k < LANES; k++) begin
                  out_lane_in[k] = merged[k];
               end
               for (int j = 0; j < LANES - 1; j++) begin
                  store_in[j] = merged[LANES + j];
               end
               cnt_in = OW'(total - PW'(LANES));
            end else begin
               for (int j = 0; j < LANES - 1; j++) begin
                  store_in[j] = merged[j];
               end
               cnt_in = OW'(total);
            end
         end
         CMD_PURGE: begin
            out_count_in = CW'(cnt_ff);
            for (int k = 0; k < LANES - 1; k++) begin
               if (PW'(k) < PW'(cnt_ff)) begin
                  out_lane_in[k] = store_ff[k];
               end
            end
            cnt_in = '0;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   assign out_valid_in = consume ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (consume) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (consume) begin
         store_ff     <= store_in;
         out_count_ff <= out_count_in;
         out_lane_ff  <= out_lane_in;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_count = out_count_ff;
   assign rsp_ch.out_lane  = out_lane_ff;

   `NLCB_ASSERT_NOW(a_cnt_range, 1'b1, PW'(cnt_ff) < PW'(LANES), "leftover count out of range")
   `NLCB_ASSERT_NOW(a_out_count, out_valid_ff, out_count_ff <= CW'(LANES), "result count too large")
   `NLCB_ASSERT_NOW(a_empty_zero, out_valid_ff && (out_count_ff == '0), out_lane_ff == '0, "empty result carries data")
   `NLCB_ASSERT_NEXT(a_purge_clear, consume && (ctrl.cmd == CMD_PURGE), cnt_ff == '0, "purge left values")
   `NLCB_ASSERT_NEXT(a_push_count, consume && (ctrl.cmd == CMD_PUSH), (out_count_ff == '0) || (out_count_ff == CW'(LANES)), "push result count not zero or full")

endmodule

@@ bench/nlcb_compaction_monitor.sv @@
// ----------------------------------------------------------------------------
// nlcb_compaction_monitor
// Predicts and checks every response of the nonzero lane compaction buffer.
// ----------------------------------------------------------------------------
// Watches both channels. Every request transfer runs through a private copy
// of the compaction behavior: zero lanes are dropped, the remaining lanes go
// in lane order behind the leftover values, and a full vector comes out once
// LANES values are held. A purge returns the leftover values and empties the
// buffer. The predicted vector is queued. Every response transfer is checked
// field by field against the oldest queued vector.
`timescale 1ns / 1ps

module nlcb_compaction_monitor #(
   parameter int LANES      = nlcb_pkg::LANES_DEF,
   parameter int DATA_WIDTH = nlcb_pkg::DATA_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  nlcb_pkg::cmd_type                req_cmd,
   input  logic [LANES-1:0][DATA_WIDTH-1:0] req_lane,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [$clog2(LANES+1)-1:0]       rsp_count,
   input  logic [LANES-1:0][DATA_WIDTH-1:0] rsp_lane,
   output int                               error_count,
   output int                               pending_count,
   output int                               checked_count,
   output int                               full_count
);
   import nlcb_pkg::*;

   localparam int CNT_W = $clog2(LANES + 1);

   typedef logic [LANES-1:0][DATA_WIDTH-1:0] lane_vector_type;

   typedef struct {
      logic [CNT_W-1:0] count;
      lane_vector_type  lanes;
   } packed_vector_type;

   logic [DATA_WIDTH-1:0] leftover [LANES-1];
   int                    held;
   packed_vector_type     expected_vectors [$];
   packed_vector_type     want;
   int                    errors;
   int                    checked;
   int                    fulls;

   initial begin
      error_count   = 0;
      pending_count = 0;
      checked_count = 0;
      full_count    = 0;
      errors        = 0;
      checked       = 0;
      fulls         = 0;
      held          = 0;
   end

   function automatic packed_vector_type compact_step(cmd_type cmd, lane_vector_type lanes);
      logic [DATA_WIDTH-1:0] merged [2*LANES];
      int                    total;
      packed_vector_type     res;
      res.count = '0;
      res.lanes = '0;
      total     = 0;
      if (cmd == CMD_PURGE) begin
         res.count = CNT_W'(held);
         for (int j = 0; j < held; j++) res.lanes[j] = leftover[j];
         held = 0;
         return res;
      end
      for (int j = 0; j < held; j++) begin
         merged[total] = leftover[j];
         total = total + 1;
      end
      for (int j = 0; j < LANES; j++) begin
         if (lanes[j] != '0) begin
            merged[total] = lanes[j];
            total = total + 1;
         end
      end
      if (total >= LANES) begin
         res.count = CNT_W'(LANES);
         for (int j = 0; j < LANES; j++) res.lanes[j] = merged[j];
         held = total - LANES;
         for (int j = 0; j < held; j++) leftover[j] = merged[LANES + j];
      end else begin
         held = total;
         for (int j = 0; j < held; j++) leftover[j] = merged[j];
      end
      return res;
   endfunction

   // Check the response first: a response never belongs to a request taken
   // at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         held = 0;
         expected_vectors.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_vectors.size() == 0) begin
               $display("%0t: response expected none actual count %0d", $time, rsp_count);
               errors = errors + 1;
            end else begin
               want    = expected_vectors.pop_front();
               checked = checked + 1;
               if (want.count == CNT_W'(LANES)) fulls = fulls + 1;
               if (rsp_count !== want.count) begin
                  $display("%0t: out_count expected %0d actual %0d",
                           $time, want.count, rsp_count);
                  errors = errors + 1;
               end
               for (int j = 0; j < LANES; j++) begin
                  if (rsp_lane[j] !== want.lanes[j]) begin
                     $display("%0t: out_%0d expected %h actual %h",
                              $time, j, want.lanes[j], rsp_lane[j]);
                     errors = errors + 1;
                  end
               end
            end
         end
         if (req_valid && req_ready)
            expected_vectors.push_back(compact_step(req_cmd, req_lane));
      end
      error_count   <= errors;
      pending_count <= expected_vectors.size();
      checked_count <= checked;
      full_count    <= fulls;
   end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the nonzero lane compaction buffer.
// ----------------------------------------------------------------------------
// Sends a directed set of vectors (purge of an empty buffer, all-zero and
// all-nonzero vectors, exact fill, maximum leftover, back to back purges),
// then random vectors with sparse, dense and mixed lane patterns and random
// purges. Both channels idle in random bursts, except in the final stretch.
// The monitor beside the block predicts and checks every response.
`timescale 1ns / 1ps

module tb_top;
   import nlcb_pkg::*;

   localparam int LANES          = LANES_DEF;
   localparam int DATA_WIDTH     = DATA_WIDTH_DEF;
   localparam int RANDOM_ITEMS   = 400;
   localparam int CALM_ITEMS     = 60;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef logic [LANES-1:0][DATA_WIDTH-1:0] lane_vector_type;

   logic clock = 1'b0;
   logic reset;
   bit   idling_on;
   int   sent_count;
   int   purge_count;
   int   quiet_cycles;
   int   error_count;
   int   pending_count;
   int   checked_count;
   int   full_count;

   nlcb_req_if #(.LANES(LANES), .DATA_WIDTH(DATA_WIDTH)) req_ch ();
   nlcb_rsp_if #(.LANES(LANES), .DATA_WIDTH(DATA_WIDTH)) rsp_ch ();

   nonzero_lane_compaction_buffer #(.LANES(LANES), .DATA_WIDTH(DATA_WIDTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   nlcb_compaction_monitor #(.LANES(LANES), .DATA_WIDTH(DATA_WIDTH)) monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_cmd       (req_ch.cmd),
      .req_lane      (req_ch.lane),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_count     (rsp_ch.out_count),
      .rsp_lane      (rsp_ch.out_lane),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .full_count    (full_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [DATA_WIDTH-1:0] lane_value();
      logic [DATA_WIDTH-1:0] v;
      case ($urandom_range(0, 7))
         0: v = '1;
         1: v = DATA_WIDTH'(1) << $urandom_range(0, DATA_WIDTH - 1);
         2: v = ~(DATA_WIDTH'(1) << $urandom_range(0, DATA_WIDTH - 1));
         default: begin
            v = DATA_WIDTH'($urandom);
            if (v == '0) v = DATA_WIDTH'(1);
         end
      endcase
      return v;
   endfunction

   function automatic lane_vector_type vector_from_mask(logic [LANES-1:0] mask);
      lane_vector_type v;
      for (int j = 0; j < LANES; j++) v[j] = mask[j] ? lane_value() : '0;
      return v;
   endfunction

   function automatic lane_vector_type random_vector();
      logic [LANES-1:0] mask;
      int               fill;
      fill = $urandom_range(0, 9);
      for (int j = 0; j < LANES; j++) begin
         case (fill)
            0:       mask[j] = 1'b0;
            1:       mask[j] = 1'b1;
            2, 3, 4: mask[j] = ($urandom_range(0, 3) == 0);
            5, 6, 7: mask[j] = ($urandom_range(0, 3) != 0);
            default: mask[j] = 1'($urandom_range(0, 1));
         endcase
      end
      return vector_from_mask(mask);
   endfunction

   task automatic transfer_vector(input cmd_type cmd, input lane_vector_type lanes);
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= cmd;
      req_ch.lane  <= lanes;
      do @(posedge clock); while (!req_ch.ready);
      sent_count = sent_count + 1;
      if (cmd == CMD_PURGE) purge_count = purge_count + 1;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         req_ch.cmd   <= cmd_type'($urandom_range(0, 1));
         req_ch.lane  <= random_vector();
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic run_directed();
      lane_vector_type v;
      v = '1;
      transfer_vector(CMD_PURGE, v);
      transfer_vector(CMD_PUSH, '0);
      transfer_vector(CMD_PUSH, v);
      v = '0;
      v[LANES-1] = DATA_WIDTH'(1);
      transfer_vector(CMD_PUSH, v);
      transfer_vector(CMD_PUSH, vector_from_mask(8'hFF));
      transfer_vector(CMD_PUSH, vector_from_mask(8'hFE));
      transfer_vector(CMD_PUSH, vector_from_mask(8'h15));
      transfer_vector(CMD_PURGE, vector_from_mask(8'hFF));
      transfer_vector(CMD_PURGE, '0);
      transfer_vector(CMD_PUSH, vector_from_mask(8'h7F));
      transfer_vector(CMD_PUSH, vector_from_mask(8'hFF));
      transfer_vector(CMD_PUSH, '0);
      v = '0;
      v[0] = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      transfer_vector(CMD_PUSH, v);
      transfer_vector(CMD_PUSH, vector_from_mask(8'h3F));
      transfer_vector(CMD_PUSH, vector_from_mask(8'hC0));
      transfer_vector(CMD_PUSH, vector_from_mask(8'h7F));
      transfer_vector(CMD_PURGE, '0);
      transfer_vector(CMD_PUSH, vector_from_mask(8'h0F));
      transfer_vector(CMD_PURGE, '0);
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d responses outstanding",
                  $time, pending_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      idling_on    = 1'b1;
      sent_count   = 0;
      purge_count  = 0;
      quiet_cycles = 0;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.cmd   <= CMD_PUSH;
      req_ch.lane  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - CALM_ITEMS) idling_on = 1'b0;
         if ($urandom_range(0, 9) == 0)
            transfer_vector(CMD_PURGE, random_vector());
         else
            transfer_vector(CMD_PUSH, random_vector());
      end
      req_ch.valid <= 1'b0;

      // hold until the monitor has seen the final transfer
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d vectors including %0d purges; checked %0d responses, %0d full.",
               sent_count, purge_count, checked_count, full_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
